// ----- hdl/cpw_pkg.sv -----
// Shared types and constants for the cell palette pixel writer.
package cpw_pkg;

    // Eight row bytes of one cell, row 0 in the low byte.
    typedef logic [7:0][7:0] cpw_rows_t;

    // Four slot colours of one cell, slot 0 in the low byte.
    typedef logic [3:0][7:0] cpw_slots_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BIT_MASK        = 2'd0,
        REG_PIXEL_WIDTH     = 2'd1,
        REG_FIRST_FREE_SLOT = 2'd2,
        REG_SLOT_COUNT      = 2'd3
    } cpw_reg_idx_t;

    // Colour value that marks a slot as free.
    localparam logic [7:0] SLOT_FREE = 8'hFF;

    // Slot contents of a cell after reset: slot 0 black, the rest free.
    localparam cpw_slots_t SLOTS_RESET = {SLOT_FREE, SLOT_FREE, SLOT_FREE, 8'h00};

    // Row contents of a cell after reset.
    localparam cpw_rows_t ROWS_RESET = '0;

endpackage

// ----- hdl/cpw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module cpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cell_palette_pixel_writer.sv -----
// Top level of the cell palette pixel writer: sequencer, usage scanner and cell stores.
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ---------------------------
//   in       sink       in_valid / in_stall    action, x, y, color
//   out      source     out_valid / out_stall  read_color
//   cfg      sink       cfg_wr_en              cfg_index, cfg_data
//
// An in-range read goes through locate, fetch and load; the result step offers its result.
// An in-range write goes through locate, fetch, load, the usage scanner (one row a cycle),
// free and pick. An out-of-range read returns 0; an out-of-range write ends after locate.
// After reset a clearing pass writes every one of the CELLS_ACROSS*CELLS_DOWN cells (1000 by
// default) to its reset contents; no item is accepted during it, configuration is.
// A finished result waits in the output register; a second read holds the input until it leaves.
module cell_palette_pixel_writer
    import cpw_pkg::*;
#(
    parameter int CELLS_ACROSS = 40,
    parameter int CELLS_DOWN   = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [8:0] x,
    input  logic [7:0] y,
    input  logic [7:0] color,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_color,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);

    localparam int NCELLS = CELLS_ACROSS * CELLS_DOWN;
    localparam int ADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int XLIM_W = 10;
    localparam int YLIM_W = 9;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_FREE,
        ST_PICK,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              action_reg, action_next;
    logic [8:0]        x_reg, x_next;
    logic [7:0]        y_reg, y_next;
    logic [7:0]        color_reg, color_next;
    logic [ADDR_W-1:0] cell_reg, cell_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        bit_reg, bit_next;
    logic              oob_reg, oob_next;
    cpw_rows_t         rows_reg, rows_next;
    cpw_slots_t        slots_reg, slots_next;
    logic [2:0]        scan_cnt_reg, scan_cnt_next;
    logic [3:0]        used_reg, used_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        read_color_reg, read_color_next;

    logic [1:0] bit_mask_reg;
    logic [1:0] pixel_width_reg;
    logic [1:0] first_free_reg;
    logic [2:0] slot_count_reg;

    // Memory ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cpw_rows_t         rows_wdata;
    cpw_slots_t        slots_wdata;
    logic              mem_re;
    cpw_rows_t         rows_rdata;
    cpw_slots_t        slots_rdata;

    // Derived configuration.
    logic       wide;
    logic [2:0] n_eff;
    logic [1:0] n_last;

    // Locate results.
    logic [6:0]  cell_x;
    logic [12:0] cell_full;
    logic        loc_ok;
    logic [2:0]  loc_bit;

    // Pixel code under the addressed pixel.
    logic [7:0] cur_byte;
    logic [8:0] cur_shift;
    logic [1:0] cur_code;

    // Usage scanner.
    logic [7:0] scan_byte;
    logic [8:0] scan_shift;
    logic [1:0] scan_code;
    logic [3:0] scan_hit;

    // Freeing and slot choice.
    cpw_slots_t slots_freed;
    logic       match_found;
    logic [1:0] match_idx;
    logic       free_found;
    logic [1:0] free_idx;
    logic [1:0] pick;
    logic       slot_wr;
    cpw_slots_t slots_new;
    logic [9:0] clr_mask_w;
    logic [9:0] pick_w;
    logic [7:0] new_byte;
    cpw_rows_t  rows_new;

    logic out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_mask_reg    <= 2'd3;
            pixel_width_reg <= 2'd2;
            first_free_reg  <= 2'd1;
            slot_count_reg  <= 3'd4;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BIT_MASK:        bit_mask_reg    <= cfg_data[1:0];
                REG_PIXEL_WIDTH:     pixel_width_reg <= cfg_data[1:0];
                REG_FIRST_FREE_SLOT: first_free_reg  <= cfg_data[1:0];
                REG_SLOT_COUNT:      slot_count_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Effective pixel width and slot count.
    always_comb
    begin
        wide = pixel_width_reg[1];
        if (slot_count_reg == 3'd0)
        begin
            n_eff = 3'd1;
        end
        else if (slot_count_reg > 3'd4)
        begin
            n_eff = 3'd4;
        end
        else
        begin
            n_eff = slot_count_reg;
        end
        n_last = 2'(n_eff - 3'd1);
    end

    // Pixel location: cell index, row and bit position, with the range check.
    always_comb
    begin
        if (wide)
        begin
            cell_x  = x_reg[8:2];
            loc_bit = {x_reg[1:0], 1'b0};
            loc_ok  = {1'b0, x_reg} < XLIM_W'(CELLS_ACROSS * 4);
        end
        else
        begin
            cell_x  = {1'b0, x_reg[8:3]};
            loc_bit = x_reg[2:0];
            loc_ok  = {1'b0, x_reg} < XLIM_W'(CELLS_ACROSS * 8);
        end
        loc_ok    = loc_ok && ({1'b0, y_reg} < YLIM_W'(CELLS_DOWN * 8));
        cell_full = 13'(cell_x) + 13'(CELLS_ACROSS) * 13'(y_reg[7:3]);
    end

    // Code of the addressed pixel in the held row byte.
    always_comb
    begin
        cur_byte  = rows_reg[row_reg];
        cur_shift = {1'b0, cur_byte} >> bit_reg;
        cur_code  = cur_shift[1:0] & bit_mask_reg;
    end

    // Usage scanner: marks every slot number that a code of one row byte selects.
    always_comb
    begin
        scan_byte  = rows_reg[scan_cnt_reg];
        scan_hit   = '0;
        scan_shift = '0;
        scan_code  = '0;
        for (int i = 0; i < 8; i++)
        begin
            scan_shift = {1'b0, scan_byte} >> (wide ? 3'(2 * i) : 3'(i));
            scan_code  = scan_shift[1:0] & bit_mask_reg;
            if (!wide || i < 4)
            begin
                scan_hit[scan_code] = 1'b1;
            end
        end
    end

    // Free every allocatable slot that no pixel of the cell uses.
    always_comb
    begin
        slots_freed = slots_reg;
        for (int s = 0; s < 4; s++)
        begin
            if (2'(s) >= first_free_reg && 3'(s) < n_eff && !used_reg[s])
            begin
                slots_freed[s] = SLOT_FREE;
            end
        end
    end

    // Slot choice for a write and the updated cell contents.
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (3'(i) < n_eff && slots_reg[i] == color_reg)
            begin
                match_found = 1'b1;
                match_idx   = 2'(i);
            end
            if (2'(i) >= first_free_reg && 3'(i) < n_eff && slots_reg[i] == SLOT_FREE)
            begin
                free_found = 1'b1;
                free_idx   = 2'(i);
            end
        end

        slot_wr = 1'b0;
        if (match_found)
        begin
            pick = match_idx;
        end
        else
        begin
            if (free_found)
            begin
                pick = free_idx;
            end
            else if (cur_code == 2'd0 && first_free_reg != 2'd0)
            begin
                pick = n_last;
            end
            else
            begin
                pick = cur_code;
            end
            slot_wr = (pick >= first_free_reg);
        end

        slots_new = slots_reg;
        if (slot_wr)
        begin
            slots_new[pick] = color_reg;
        end

        clr_mask_w = {8'd0, bit_mask_reg} << bit_reg;
        pick_w     = {8'd0, pick} << bit_reg;
        new_byte   = (cur_byte & ~clr_mask_w[7:0]) | pick_w[7:0];
        rows_new   = rows_reg;
        rows_new[row_reg] = new_byte;
    end

    // Memory port control: clearing pass or write-back of the updated cell.
    always_comb
    begin
        mem_re = (state_reg == ST_FETCH);
        if (state_reg == ST_CLEAR)
        begin
            mem_we      = 1'b1;
            mem_waddr   = clr_cnt_reg;
            rows_wdata  = ROWS_RESET;
            slots_wdata = SLOTS_RESET;
        end
        else
        begin
            mem_we      = (state_reg == ST_PICK);
            mem_waddr   = cell_reg;
            rows_wdata  = rows_new;
            slots_wdata = slots_new;
        end
    end

    cpw_ram #(
        .WIDTH(64),
        .DEPTH(NCELLS)
    ) u_rows_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (rows_wdata),
        .re    (mem_re),
        .raddr (cell_reg),
        .rdata (rows_rdata)
    );

    cpw_ram #(
        .WIDTH(32),
        .DEPTH(NCELLS)
    ) u_slots_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (slots_wdata),
        .re    (mem_re),
        .raddr (cell_reg),
        .rdata (slots_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        action_next     = action_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        color_next      = color_reg;
        cell_next       = cell_reg;
        row_next        = row_reg;
        bit_next        = bit_reg;
        oob_next        = oob_reg;
        rows_next       = rows_reg;
        slots_next      = slots_reg;
        scan_cnt_next   = scan_cnt_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_color_next = read_color_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(NCELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    x_next      = x;
                    y_next      = y;
                    color_next  = color;
                    state_next  = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                cell_next = cell_full[ADDR_W-1:0];
                row_next  = y_reg[2:0];
                bit_next  = loc_bit;
                oob_next  = !loc_ok;
                if (loc_ok)
                begin
                    state_next = ST_FETCH;
                end
                else if (action_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rows_next     = rows_rdata;
                slots_next    = slots_rdata;
                scan_cnt_next = '0;
                used_next     = '0;
                state_next    = action_reg ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN:
            begin
                used_next     = used_reg | scan_hit;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == 3'd7)
                begin
                    state_next = ST_FREE;
                end
            end
            ST_FREE:
            begin
                slots_next = slots_freed;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    read_color_next = oob_reg ? 8'd0 : slots_reg[cur_code];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            action_reg     <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            color_reg      <= '0;
            cell_reg       <= '0;
            row_reg        <= '0;
            bit_reg        <= '0;
            oob_reg        <= 1'b0;
            rows_reg       <= '0;
            slots_reg      <= '0;
            scan_cnt_reg   <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            read_color_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            action_reg     <= action_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            color_reg      <= color_next;
            cell_reg       <= cell_next;
            row_reg        <= row_next;
            bit_reg        <= bit_next;
            oob_reg        <= oob_next;
            rows_reg       <= rows_next;
            slots_reg      <= slots_next;
            scan_cnt_reg   <= scan_cnt_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            read_color_reg <= read_color_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_color = read_color_reg;

`ifndef SYNTHESIS
    // An accepted item closes the input until its work is done.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // A new result appears only out of the result step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside the result step");

    // The cell stores are written only by the clearing pass or a write-back.
    a_mem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || (state_reg == ST_PICK && !action_reg)))
        else $error("cell store written outside clearing or write-back");

    // Write addresses of the clearing pass and of write-backs stay inside the store.
    a_mem_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, mem_waddr} < (ADDR_W + 1)'(NCELLS)))
        else $error("cell store address out of range");
`endif

endmodule
